[rtl/core/gsp_pkg.sv]
// gsp_pkg: shared types, constants and helpers for the gain-scheduled PID core.
// Depends on nothing; used by gsp_cfg_regs, gsp_law and gain_scheduled_pid_core.
package gsp_pkg;

  localparam int unsigned DataW    = 16;
  localparam int unsigned ErrW     = DataW + 1;
  localparam int unsigned GainW    = 16;
  localparam int unsigned FracBits = 8;
  localparam int unsigned SumW     = 2 * DataW + 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 3 * GainW;
  localparam int unsigned BandW    = 2;

  localparam logic [CfgIdxW-1:0] CfgBandLimitLow = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBandLimitMid = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGainsBand0   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgGainsBand1   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgGainsBand2   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgOutMin       = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgOutMax       = 3'd6;

  localparam logic [BandW-1:0] Band0 = 2'd0;
  localparam logic [BandW-1:0] Band1 = 2'd1;
  localparam logic [BandW-1:0] Band2 = 2'd2;

  localparam logic CmdStep  = 1'b0;
  localparam logic CmdClear = 1'b1;

  typedef struct packed {
    logic                    command;
    logic signed [DataW-1:0] setpoint;
    logic signed [DataW-1:0] measured;
  } gsp_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] drive;
    logic [BandW-1:0]        band;
  } gsp_out_t;

  typedef struct packed {
    logic [GainW-1:0] kp;
    logic [GainW-1:0] ki;
    logic [GainW-1:0] kd;
  } gsp_gains_t;

  typedef struct packed {
    logic signed [DataW-1:0] band_limit_low;
    logic signed [DataW-1:0] band_limit_mid;
    gsp_gains_t [2:0]        gains;
    logic signed [DataW-1:0] out_min;
    logic signed [DataW-1:0] out_max;
  } gsp_cfg_t;

  // below min gives min, else above max gives max
  function automatic logic signed [DataW-1:0] clamp_limits(
    input logic signed [SumW-1:0]  v,
    input logic signed [DataW-1:0] lo,
    input logic signed [DataW-1:0] hi
  );
    logic signed [DataW-1:0] r;
    if (v < SumW'(lo)) begin
      r = lo;
    end else if (v > SumW'(hi)) begin
      r = hi;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/gain_scheduled_pid_core.sv]
// gain_scheduled_pid_core: top level of the gain-scheduled PID controller.
// Depends on gsp_pkg, gsp_cfg_regs and gsp_law.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid_i  in_ready_o  in_i                   | sink
//   out     | out_valid_o out_ready_i out_o                  | source
//   cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | sink
//
// One transaction per cycle sustained while the output side accepts results; a result
// passes from the input register through the PID step into the result register.
// A clear command updates the integrator only and never waits on the output side.
// A stalled result holds the step stage, and the input register takes no new input.
// Reset: integrator and last error zero, limits at full range, gains zero.
module gain_scheduled_pid_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  gsp_pkg::gsp_in_t              in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output gsp_pkg::gsp_out_t             out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gsp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gsp_pkg::CfgDataW-1:0]  cfg_data_i
);

  gsp_pkg::gsp_cfg_t                 cfg;
  gsp_pkg::gsp_in_t                  in_q;
  logic                              in_valid_q;
  gsp_pkg::gsp_out_t                 out_q, res;
  logic                              out_valid_q;
  logic signed [gsp_pkg::DataW-1:0]  integral_d, integral_q;
  logic signed [gsp_pkg::ErrW-1:0]   last_error_d, last_error_q;
  logic                              adv;

  gsp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  gsp_law u_law (
    .cfg_i        (cfg),
    .in_i         (in_q),
    .integral_i   (integral_q),
    .last_error_i (last_error_q),
    .res_o        (res),
    .integral_o   (integral_d),
    .last_error_o (last_error_d)
  );

  assign adv = in_valid_q &&
               ((in_q.command == gsp_pkg::CmdClear) || !out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || adv;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      integral_q   <= '0;
      last_error_q <= '0;
    end else begin
      if (adv && (in_q.command == gsp_pkg::CmdStep)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (adv) begin
        integral_q   <= integral_d;
        last_error_q <= last_error_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && (in_q.command == gsp_pkg::CmdStep)) begin
      out_q <= res;
    end
  end

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (in_q.command == gsp_pkg::CmdClear) |=> integral_q == '0)
    else $error("integrator not cleared by clear command");

  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (in_q.command == gsp_pkg::CmdStep) |=> out_valid_q)
    else $error("control step produced no result");

  a_stall_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a blocked result");

  a_band_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.band == gsp_pkg::Band0) || (out_o.band == gsp_pkg::Band1) ||
                    (out_o.band == gsp_pkg::Band2))
    else $error("band index out of range");

endmodule

[rtl/core/gsp_cfg_regs.sv]
// gsp_cfg_regs: configuration register file (band limits, gains, drive limits).
// Depends on gsp_pkg.
module gsp_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gsp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [gsp_pkg::CfgDataW-1:0]   cfg_data_i,
  output gsp_pkg::gsp_cfg_t              cfg_o
);

  gsp_pkg::gsp_cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gsp_pkg::CfgBandLimitLow: cfg_d.band_limit_low = cfg_data_i[gsp_pkg::DataW-1:0];
        gsp_pkg::CfgBandLimitMid: cfg_d.band_limit_mid = cfg_data_i[gsp_pkg::DataW-1:0];
        gsp_pkg::CfgGainsBand0:   cfg_d.gains[0]       = cfg_data_i;
        gsp_pkg::CfgGainsBand1:   cfg_d.gains[1]       = cfg_data_i;
        gsp_pkg::CfgGainsBand2:   cfg_d.gains[2]       = cfg_data_i;
        gsp_pkg::CfgOutMin:       cfg_d.out_min        = cfg_data_i[gsp_pkg::DataW-1:0];
        gsp_pkg::CfgOutMax:       cfg_d.out_max        = cfg_data_i[gsp_pkg::DataW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.band_limit_low <= 16'sh7fff;
      cfg_q.band_limit_mid <= 16'sh7fff;
      cfg_q.gains          <= '0;
      cfg_q.out_min        <= 16'sh8000;
      cfg_q.out_max        <= 16'sh7fff;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/core/gsp_law.sv]
// gsp_law: combinational PID step - band select, gain products, anti-windup, clamp.
// Depends on gsp_pkg.
module gsp_law (
  input  gsp_pkg::gsp_cfg_t                   cfg_i,
  input  gsp_pkg::gsp_in_t                    in_i,
  input  logic signed [gsp_pkg::DataW-1:0]    integral_i,
  input  logic signed [gsp_pkg::ErrW-1:0]     last_error_i,
  output gsp_pkg::gsp_out_t                   res_o,
  output logic signed [gsp_pkg::DataW-1:0]    integral_o,
  output logic signed [gsp_pkg::ErrW-1:0]     last_error_o
);

  localparam int unsigned GainSW = gsp_pkg::GainW + 1;
  localparam int unsigned AccW   = gsp_pkg::ErrW + 1;
  localparam int unsigned PW     = GainSW + gsp_pkg::ErrW;
  localparam int unsigned IW     = GainSW + AccW;
  localparam int unsigned SumW   = gsp_pkg::SumW;

  logic [gsp_pkg::BandW-1:0]        band;
  gsp_pkg::gsp_gains_t              g;
  logic signed [gsp_pkg::ErrW-1:0]  err;
  logic signed [AccW-1:0]           ierr, derr;
  logic signed [GainSW-1:0]         kp_s, ki_s, kd_s;
  logic signed [PW-1:0]             p_prod;
  logic signed [IW-1:0]             i_prod, d_prod;
  logic signed [SumW-1:0]           sum, drive_raw, pterm, acc;
  logic signed [SumW-1:0]           lo_w, hi_w;
  logic                             p_hit, in_range;

  always_comb begin
    if (in_i.setpoint <= cfg_i.band_limit_low) begin
      band = gsp_pkg::Band0;
    end else if (in_i.setpoint <= cfg_i.band_limit_mid) begin
      band = gsp_pkg::Band1;
    end else begin
      band = gsp_pkg::Band2;
    end
  end

  always_comb begin
    case (band)
      gsp_pkg::Band0: g = cfg_i.gains[0];
      gsp_pkg::Band1: g = cfg_i.gains[1];
      default:        g = cfg_i.gains[2];
    endcase
  end

  assign err  = gsp_pkg::ErrW'(in_i.setpoint) - gsp_pkg::ErrW'(in_i.measured);
  assign ierr = AccW'(integral_i) + AccW'(err);
  assign derr = AccW'(err) - AccW'(last_error_i);

  assign kp_s = $signed({1'b0, g.kp});
  assign ki_s = $signed({1'b0, g.ki});
  assign kd_s = $signed({1'b0, g.kd});

  assign p_prod = PW'(kp_s) * PW'(err);
  assign i_prod = IW'(ki_s) * IW'(ierr);
  assign d_prod = IW'(kd_s) * IW'(derr);

  assign sum       = SumW'(p_prod) + SumW'(i_prod) + SumW'(d_prod);
  assign drive_raw = sum >>> gsp_pkg::FracBits;
  assign pterm     = SumW'(p_prod) >>> gsp_pkg::FracBits;

  assign lo_w = SumW'(cfg_i.out_min);
  assign hi_w = SumW'(cfg_i.out_max);

  assign p_hit = ((cfg_i.out_max != '0) && (pterm > hi_w)) ||
                 ((cfg_i.out_min != '0) && (pterm < lo_w));
  assign in_range = ((cfg_i.out_min == '0) || (drive_raw > lo_w)) &&
                    ((cfg_i.out_max == '0) || (drive_raw < hi_w));

  always_comb begin
    if (p_hit) begin
      acc = '0;
    end else if (in_range) begin
      acc = SumW'(ierr);
    end else begin
      acc = SumW'(integral_i);
    end
  end

  always_comb begin
    res_o.band  = band;
    res_o.drive = gsp_pkg::clamp_limits(drive_raw, cfg_i.out_min, cfg_i.out_max);
    if (in_i.command == gsp_pkg::CmdClear) begin
      integral_o   = '0;
      last_error_o = last_error_i;
    end else begin
      integral_o   = gsp_pkg::clamp_limits(acc, cfg_i.out_min, cfg_i.out_max);
      last_error_o = err;
    end
  end

endmodule
